// ----- rtl/core/bcrq_pkg.sv -----
// Shared types, constants and register codes for the bilinear crop, resize and quantize block.
package bcrq_pkg;

  // Default geometry of the output grid and of the frame store.
  localparam int OUT_W_DEF       = 112;
  localparam int OUT_H_DEF       = 112;
  localparam int MAX_FRAME_W_DEF = 256;
  localparam int MAX_FRAME_H_DEF = 256;

  // Configuration port geometry.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;

  // Fixed-point unity with 16 fraction bits, and the width of a blend weight.
  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam int          WGT_W   = 33;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Request kinds.
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_CROP_LEFT    = 3'd2,
    CFG_CROP_TOP     = 3'd3,
    CFG_CROP_WIDTH   = 3'd4,
    CFG_CROP_HEIGHT  = 3'd5
  } cfg_idx_t;

  // Input beat.
  typedef struct packed {
    logic        req_type;
    logic [15:0] pixel_address;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [6:0]  target_x;
    logic [6:0]  target_y;
  } req_t;

  // Result beat.
  typedef struct packed {
    logic [6:0]        result_x;
    logic [6:0]        result_y;
    logic signed [7:0] result_red;
    logic signed [7:0] result_green;
    logic signed [7:0] result_blue;
  } res_t;

  // Configuration register file.
  typedef struct packed {
    logic [8:0] frame_width;
    logic [8:0] frame_height;
    logic [7:0] crop_left;
    logic [7:0] crop_top;
    logic [8:0] crop_width;
    logic [8:0] crop_height;
  } cfg_t;

endpackage

// ----- rtl/core/bcrq_ram.sv -----
// Generic single-port RAM with a registered read.
module bcrq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write or one read per cycle; the read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/core/bcrq_fifo.sv -----
// Short register queue that decouples the front from the back.
module bcrq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/bcrq_front.sv -----
// Front pipeline: accepts beats, drops loads beyond the store, maps computes to addresses and weights.
module bcrq_front #(
  parameter int OUT_W       = 112,
  parameter int OUT_H       = 112,
  parameter int MAX_FRAME_W = 256,
  parameter int MAX_FRAME_H = 256,
  parameter int ENT_W       = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  bcrq_pkg::req_t     in_data,
  output logic               in_stall,
  input  bcrq_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               q_push,
  output logic [ENT_W-1:0]   q_entry
);
  import bcrq_pkg::*;

  localparam int DEPTH = MAX_FRAME_W * MAX_FRAME_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int FWW   = $clog2(MAX_FRAME_W + 1);
  localparam int FHW   = $clog2(MAX_FRAME_H + 1);
  localparam int IXW   = $clog2(MAX_FRAME_W);
  localparam int IYW   = $clog2(MAX_FRAME_H);
  localparam int NW    = 25;
  localparam int K     = NW;
  localparam int ODX   = $clog2(OUT_W + 1);
  localparam int ODY   = $clog2(OUT_H + 1);
  localparam int PW    = NW + 9;
  localparam int NST   = 6;
  localparam logic [K-1:0] REC_X = K'((64'd1 << K) / OUT_W);
  localparam logic [K-1:0] REC_Y = K'((64'd1 << K) / OUT_H);

  logic             en;
  logic [NST:1]     v_r;
  req_t             st_r [NST:1];
  logic [31:0]      fw_raw, fh_raw;
  logic [FWW-1:0]   fw_c;
  logic [FHW-1:0]   fh_c;
  logic [NW-1:0]    nx, ny;
  logic             bad_load;

  logic [2*NW-1:0]  pm_x_r, pm_y_r;
  logic [NW-1:0]    q0x_r, q0y_r;
  logic [NW+ODX-1:0] qdx_r;
  logic [NW+ODY-1:0] qdy_r;
  logic [NW+ODX-1:0] remx;
  logic [NW+ODY-1:0] remy;
  logic [NW-1:0]    scx_r, scy_r;
  logic [PW-1:0]    px_r, py_r;
  logic [PW-2:0]    fx, fy;
  logic [IXW-1:0]   ix, ix_r;
  logic [IYW-1:0]   iy, iy_r;
  logic [16:0]      dx, dy, dx_r, dy_r;
  logic [AW-1:0]    a00;
  logic [AW-1:0]    addr_r;
  logic [WGT_W-1:0] w00_r, w01_r, w10_r, w11_r;

  // The whole front moves as one; it halts only when its last stage cannot enter the queue.
  assign en       = !(v_r[NST] && q_full);
  assign in_stall = !en;
  assign q_push   = v_r[NST];

  // Frame size clamped into the supported range.
  always_comb begin
    fw_raw = 32'(cfg.frame_width);
    fh_raw = 32'(cfg.frame_height);
    if (fw_raw < 32'd2) begin
      fw_c = FWW'(2);
    end else if (fw_raw > 32'(MAX_FRAME_W)) begin
      fw_c = FWW'(MAX_FRAME_W);
    end else begin
      fw_c = FWW'(fw_raw);
    end
    if (fh_raw < 32'd2) begin
      fh_c = FHW'(2);
    end else if (fh_raw > 32'(MAX_FRAME_H)) begin
      fh_c = FHW'(MAX_FRAME_H);
    end else begin
      fh_c = FHW'(fh_raw);
    end
  end

  // Scale numerators, with half the divisor added for rounding.
  assign nx = {cfg.crop_width, 16'h0000} + NW'(OUT_W / 2);
  assign ny = {cfg.crop_height, 16'h0000} + NW'(OUT_H / 2);

  // Loads beyond the store are dropped on entry.
  assign bad_load = (in_data.req_type == REQ_LOAD) &&
                    (32'(in_data.pixel_address) >= 32'(DEPTH));

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-1:1], in_valid && !bad_load};
    end
  end

  // Beat fields travel alongside the arithmetic.
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[1] <= in_data;
      for (int s = 2; s <= NST; s++) begin
        st_r[s] <= st_r[s-1];
      end
    end
  end

  // Division remainders of the scale step.
  assign remx = (NW+ODX)'(nx) - qdx_r;
  assign remy = (NW+ODY)'(ny) - qdy_r;

  // Position to index and weight, with the neighbor held inside the frame.
  always_comb begin
    fx = (PW-1)'((px_r - PW'(Q16_ONE)) >> 1);
    fy = (PW-1)'((py_r - PW'(Q16_ONE)) >> 1);
    if (px_r < PW'(Q16_ONE)) begin
      ix = '0;
      dx = '0;
    end else if (32'(fx[PW-2:16]) >= 32'(fw_c) - 32'd1) begin
      ix = IXW'(32'(fw_c) - 32'd2);
      dx = Q16_ONE;
    end else begin
      ix = IXW'(fx[PW-2:16]);
      dx = {1'b0, fx[15:0]};
    end
    if (py_r < PW'(Q16_ONE)) begin
      iy = '0;
      dy = '0;
    end else if (32'(fy[PW-2:16]) >= 32'(fh_c) - 32'd1) begin
      iy = IYW'(32'(fh_c) - 32'd2);
      dy = Q16_ONE;
    end else begin
      iy = IYW'(fy[PW-2:16]);
      dy = {1'b0, fy[15:0]};
    end
  end

  assign a00 = AW'(iy_r * fw_c) + AW'(ix_r);

  // Arithmetic stages: reciprocal product, back-multiply, corrected scale,
  // position, index and weight, then address and blend weights.
  always_ff @(posedge clk) begin
    if (en) begin
      pm_x_r <= nx * REC_X;
      pm_y_r <= ny * REC_Y;
      q0x_r  <= pm_x_r[2*NW-1:K];
      q0y_r  <= pm_y_r[2*NW-1:K];
      qdx_r  <= pm_x_r[2*NW-1:K] * ODX'(OUT_W);
      qdy_r  <= pm_y_r[2*NW-1:K] * ODY'(OUT_H);
      scx_r  <= q0x_r + NW'(remx >= (NW+ODX)'(OUT_W));
      scy_r  <= q0y_r + NW'(remy >= (NW+ODY)'(OUT_H));
      px_r   <= PW'({cfg.crop_left, 17'h00000}) + PW'({st_r[3].target_x, 1'b1} * scx_r);
      py_r   <= PW'({cfg.crop_top, 17'h00000}) + PW'({st_r[3].target_y, 1'b1} * scy_r);
      ix_r   <= ix;
      iy_r   <= iy;
      dx_r   <= dx;
      dy_r   <= dy;
      addr_r <= (st_r[5].req_type == REQ_LOAD) ? AW'(st_r[5].pixel_address) : a00;
      w00_r  <= (Q16_ONE - dx_r) * (Q16_ONE - dy_r);
      w01_r  <= dx_r * (Q16_ONE - dy_r);
      w10_r  <= (Q16_ONE - dx_r) * dy_r;
      w11_r  <= dx_r * dy_r;
    end
  end

  // Queue entry layout: kind, address, frame width, pixel, four weights, target.
  assign q_entry = {st_r[NST].req_type, addr_r, fw_c,
                    st_r[NST].pixel_red, st_r[NST].pixel_green, st_r[NST].pixel_blue,
                    w00_r, w01_r, w10_r, w11_r,
                    st_r[NST].target_x, st_r[NST].target_y};

endmodule

// ----- rtl/core/bcrq_back.sv -----
// Back end: writes loads into the frame store and blends four neighbor reads per compute.
module bcrq_back #(
  parameter int MAX_FRAME_W = 256,
  parameter int MAX_FRAME_H = 256,
  parameter int ENT_W       = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  logic [ENT_W-1:0] q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output bcrq_pkg::res_t   out_data
);
  import bcrq_pkg::*;

  localparam int DEPTH = MAX_FRAME_W * MAX_FRAME_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int FWW   = $clog2(MAX_FRAME_W + 1);
  localparam int ACW   = WGT_W + 8;

  logic             e_load;
  logic [AW-1:0]    e_addr;
  logic [FWW-1:0]   e_fw;
  logic [23:0]      e_pix;
  logic [WGT_W-1:0] e_w [4];
  logic [6:0]       e_x, e_y;

  logic             en;
  logic             out_free;
  logic [1:0]       phase_r, phase_nxt;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_addr, offs;
  logic [23:0]      rdata;

  logic             rd_v_r, rd_first_r, rd_last_r;
  logic [WGT_W-1:0] rd_w_r;
  logic [6:0]       rd_x_r, rd_y_r;
  logic [ACW-1:0]   acc_r [3];
  logic [ACW-1:0]   sum [3];
  logic [7:0]       chn [3];
  logic             out_v_r;
  res_t             out_r;

  // Rounds the blend, removes the offset of 128 and saturates to a signed byte.
  function automatic logic [7:0] quant(input logic [ACW-1:0] s);
    logic [ACW-1:0]     r;
    logic signed [11:0] q;
    r = s + ACW'(64'h80000000);
    q = $signed({3'b000, r[ACW-1:32]}) - 12'sd128;
    if (q < -12'sd128) begin
      return 8'h80;
    end else if (q > 12'sd127) begin
      return 8'h7f;
    end
    return q[7:0];
  endfunction

  assign {e_load, e_addr, e_fw, e_pix, e_w[0], e_w[1], e_w[2], e_w[3], e_x, e_y} = q_entry;

  // The back halts while a finished blend waits for the output register.
  assign out_free = !out_v_r || !out_stall;
  assign en       = !(rd_v_r && rd_last_r && !out_free);

  // Neighbor offsets: none for the top-left, then right, below, below right.
  always_comb begin
    unique case (phase_r)
      2'd0:    offs = '0;
      2'd1:    offs = AW'(1);
      2'd2:    offs = AW'(e_fw);
      default: offs = AW'(e_fw) + AW'(1);
    endcase
  end

  // Issue: a load is one write, a compute one read per neighbor.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    q_pop     = 1'b0;
    phase_nxt = phase_r;
    ram_addr  = e_addr + offs;
    if (en && q_valid) begin
      if (e_load == REQ_LOAD) begin
        ram_we   = 1'b1;
        q_pop    = 1'b1;
        ram_addr = e_addr;
      end else begin
        ram_re    = 1'b1;
        phase_nxt = phase_r + 2'd1;
        q_pop     = (phase_r == 2'd3);
      end
    end
  end

  bcrq_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (e_pix),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (en) begin
        rd_v_r <= ram_re;
      end
    end
  end

  // Read tags that line up with the registered RAM data.
  always_ff @(posedge clk) begin
    if (en) begin
      rd_first_r <= (phase_r == 2'd0);
      rd_last_r  <= (phase_r == 2'd3);
      rd_w_r     <= e_w[phase_r];
      rd_x_r     <= e_x;
      rd_y_r     <= e_y;
    end
  end

  // Weighted sum per channel.
  assign chn[0] = rdata[23:16];
  assign chn[1] = rdata[15:8];
  assign chn[2] = rdata[7:0];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = (rd_first_r ? '0 : acc_r[c]) + ACW'(rd_w_r * chn[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en && rd_v_r && !rd_last_r) begin
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= sum[c];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en && rd_v_r && rd_last_r) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && rd_v_r && rd_last_r) begin
      out_r.result_x     <= rd_x_r;
      out_r.result_y     <= rd_y_r;
      out_r.result_red   <= quant(sum[0]);
      out_r.result_green <= quant(sum[1]);
      out_r.result_blue  <= quant(sum[2]);
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/bilinear_crop_resize_quantize.sv -----
// Top level of the bilinear crop, resize and quantize block.
// A load beat takes one write of the frame store and gives no result; a compute beat takes
// one frame store read for each of its four neighbors through the single port of that
// memory, and gives one result. Beats go through a six-stage front pipeline that maps the
// output pixel into the crop window, then a four-entry queue, then the back end. The frame
// store contents are undefined after reset and need no clearing pass.
module bilinear_crop_resize_quantize #(
  parameter int OUT_W       = bcrq_pkg::OUT_W_DEF,
  parameter int OUT_H       = bcrq_pkg::OUT_H_DEF,
  parameter int MAX_FRAME_W = bcrq_pkg::MAX_FRAME_W_DEF,
  parameter int MAX_FRAME_H = bcrq_pkg::MAX_FRAME_H_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  bcrq_pkg::req_t                 in_data,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bcrq_pkg::res_t                 out_data,
  input  logic                           cfg_we,
  input  logic [bcrq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcrq_pkg::CFG_W-1:0]     cfg_data
);
  import bcrq_pkg::*;

  localparam int DEPTH = MAX_FRAME_W * MAX_FRAME_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int FWW   = $clog2(MAX_FRAME_W + 1);
  localparam int ENT_W = 1 + AW + FWW + 24 + 4 * WGT_W + 14;

  cfg_t             cfg_r;
  logic             q_full, q_push, q_pop, q_valid;
  logic [ENT_W-1:0] q_in, q_head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= 9'd256;
      cfg_r.frame_height <= 9'd256;
      cfg_r.crop_left    <= 8'd0;
      cfg_r.crop_top     <= 8'd0;
      cfg_r.crop_width   <= 9'd112;
      cfg_r.crop_height  <= 9'd112;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data;
        CFG_CROP_LEFT:    cfg_r.crop_left    <= cfg_data[7:0];
        CFG_CROP_TOP:     cfg_r.crop_top     <= cfg_data[7:0];
        CFG_CROP_WIDTH:   cfg_r.crop_width   <= cfg_data;
        CFG_CROP_HEIGHT:  cfg_r.crop_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  bcrq_front #(
    .OUT_W       (OUT_W),
    .OUT_H       (OUT_H),
    .MAX_FRAME_W (MAX_FRAME_W),
    .MAX_FRAME_H (MAX_FRAME_H),
    .ENT_W       (ENT_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  bcrq_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  bcrq_back #(
    .MAX_FRAME_W (MAX_FRAME_W),
    .MAX_FRAME_H (MAX_FRAME_H),
    .ENT_W       (ENT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/bcrq_checker.sv -----
// Port-level checker for the bilinear crop, resize and quantize block, with its bind.
module bcrq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input bcrq_pkg::req_t in_data,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input bcrq_pkg::res_t out_data
);
  import bcrq_pkg::*;

  logic [7:0] pend_r;
  logic       in_cmp, out_acc;

  assign in_cmp  = in_valid && !in_stall && (in_data.req_type == REQ_COMPUTE);
  assign out_acc = out_valid && !out_stall;

  // Computes accepted and not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 8'(in_cmp) - 8'(out_acc);
    end
  end

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Every result answers an earlier compute beat.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 8'd0)
    else $error("result without a pending compute");

endmodule

bind bilinear_crop_resize_quantize bcrq_checker u_bcrq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_data   (in_data),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/tb_bilinear_crop_resize_quantize.sv -----
// Self-checking testbench for the bilinear crop, resize and quantize block.
module tb_bilinear_crop_resize_quantize;
  timeunit 1ns;
  timeprecision 1ps;
  import bcrq_pkg::*;

  localparam int GRID_W = OUT_W_DEF;
  localparam int GRID_H = OUT_H_DEF;
  localparam int FRAME_MAX_W = MAX_FRAME_W_DEF;
  localparam int FRAME_MAX_H = MAX_FRAME_H_DEF;
  localparam int STORE_SIZE = FRAME_MAX_W * FRAME_MAX_H;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 30;

  logic clk;
  logic rst_n;
  logic in_valid;
  req_t in_data;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  res_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bilinear_crop_resize_quantize dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow registers and frame contents as the block should hold them.
  cfg_t shadow_cfg;
  logic [23:0] frame_shadow [STORE_SIZE];
  bit loaded_addr [STORE_SIZE];

  req_t pending_beats[$];
  res_t expected_pixels[$];
  int mismatches;
  int idle_cycles;
  bit calm;
  bit hold_request;
  bit hold_done;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Maps one output coordinate to the top-left neighbor and its Q16 weight.
  function automatic void map_coord(input longint unsigned origin, input longint unsigned crop,
                                    input longint unsigned outn, input longint unsigned coord,
                                    input longint unsigned size, output int unsigned idx,
                                    output longint unsigned wgt);
    longint unsigned scale, pos, f, i;
    scale = (crop * 65536 + outn / 2) / outn;
    pos = (origin << 17) + (2 * coord + 1) * scale;
    if (pos < 65536) begin
      idx = 0;
      wgt = 0;
      return;
    end
    f = (pos - 65536) >> 1;
    i = f >> 16;
    if (i >= size - 1) i = size - 2;
    wgt = f - (i << 16);
    if (wgt > 65536) wgt = 65536;
    idx = int'(i);
  endfunction

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Neighbor addresses of an output pixel under the current shadow registers.
  function automatic void neighbor_addrs(input logic [6:0] tx, input logic [6:0] ty,
                                         output int unsigned a[4],
                                         output longint unsigned dx,
                                         output longint unsigned dy);
    int unsigned w, h, ix, iy;
    w = eff_dim(shadow_cfg.frame_width, FRAME_MAX_W);
    h = eff_dim(shadow_cfg.frame_height, FRAME_MAX_H);
    map_coord(shadow_cfg.crop_left, shadow_cfg.crop_width, GRID_W, tx, w, ix, dx);
    map_coord(shadow_cfg.crop_top, shadow_cfg.crop_height, GRID_H, ty, h, iy, dy);
    a[0] = (iy * w + ix) % STORE_SIZE;
    a[1] = (a[0] + 1) % STORE_SIZE;
    a[2] = (a[0] + w) % STORE_SIZE;
    a[3] = (a[2] + 1) % STORE_SIZE;
  endfunction

  // Blends the four neighbors and quantizes each channel to a signed byte.
  function automatic res_t blend_pixel(input req_t r);
    int unsigned a[4];
    longint unsigned dx, dy, v;
    longint unsigned wt[4];
    longint q;
    res_t res;
    logic [7:0] qb[3];
    neighbor_addrs(r.target_x, r.target_y, a, dx, dy);
    wt[0] = (65536 - dx) * (65536 - dy);
    wt[1] = dx * (65536 - dy);
    wt[2] = (65536 - dx) * dy;
    wt[3] = dx * dy;
    for (int c = 0; c < 3; c++) begin
      v = 0;
      for (int k = 0; k < 4; k++) v += wt[k] * ((frame_shadow[a[k]] >> (16 - 8 * c)) & 8'hff);
      q = longint'((v + 64'h8000_0000) >> 32) - 128;
      if (q < -128) q = -128;
      if (q > 127) q = 127;
      qb[c] = q[7:0];
    end
    res.result_x = r.target_x;
    res.result_y = r.target_y;
    res.result_red = qb[0];
    res.result_green = qb[1];
    res.result_blue = qb[2];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Driver: offers queued beats, keeps a stalled beat steady, predicts on acceptance.
  always @(posedge clk) begin
    bit held;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      held = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        if (in_data.req_type == REQ_LOAD)
          frame_shadow[in_data.pixel_address] =
            {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue};
        else
          expected_pixels.push_back(blend_pixel(in_data));
      end
      if (!held) begin
        if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
          in_valid <= 1'b1;
          in_data <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares result beats and drives the receiver stall.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result, x", out_data.result_x, -1);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.result_x !== want.result_x)
            report_mismatch("result_x", out_data.result_x, want.result_x);
          if (out_data.result_y !== want.result_y)
            report_mismatch("result_y", out_data.result_y, want.result_y);
          if (out_data.result_red !== want.result_red)
            report_mismatch("result_red", out_data.result_red, want.result_red);
          if (out_data.result_green !== want.result_green)
            report_mismatch("result_green", out_data.result_green, want.result_green);
          if (out_data.result_blue !== want.result_blue)
            report_mismatch("result_blue", out_data.result_blue, want.result_blue);
        end
      end
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 25);
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[bilinear_crop_resize_quantize] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_W-1:0];
    case (idx)
      CFG_FRAME_WIDTH:  shadow_cfg.frame_width = v[8:0];
      CFG_FRAME_HEIGHT: shadow_cfg.frame_height = v[8:0];
      CFG_CROP_LEFT:    shadow_cfg.crop_left = v[7:0];
      CFG_CROP_TOP:     shadow_cfg.crop_top = v[7:0];
      CFG_CROP_WIDTH:   shadow_cfg.crop_width = v[8:0];
      CFG_CROP_HEIGHT:  shadow_cfg.crop_height = v[8:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned fw, input int unsigned fh,
                              input int unsigned cl, input int unsigned ct,
                              input int unsigned cw, input int unsigned ch);
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    write_reg(CFG_CROP_LEFT, cl);
    write_reg(CFG_CROP_TOP, ct);
    write_reg(CFG_CROP_WIDTH, cw);
    write_reg(CFG_CROP_HEIGHT, ch);
  endtask

  function automatic req_t random_beat();
    req_t r;
    r.req_type = REQ_LOAD;
    r.pixel_address = 16'($urandom);
    r.pixel_red = 8'($urandom);
    r.pixel_green = 8'($urandom);
    r.pixel_blue = 8'($urandom);
    r.target_x = 7'($urandom);
    r.target_y = 7'($urandom);
    return r;
  endfunction

  task automatic queue_load(input int unsigned addr, input logic [23:0] rgb);
    req_t r;
    r = random_beat();
    r.pixel_address = addr[15:0];
    {r.pixel_red, r.pixel_green, r.pixel_blue} = rgb;
    loaded_addr[addr] = 1'b1;
    pending_beats.push_back(r);
  endtask

  // Queues a compute beat, first loading any neighbor never written.
  task automatic queue_compute(input logic [6:0] tx, input logic [6:0] ty, output int n);
    int unsigned a[4];
    longint unsigned dx, dy;
    req_t r;
    n = 1;
    neighbor_addrs(tx, ty, a, dx, dy);
    for (int k = 0; k < 4; k++) begin
      if (!loaded_addr[a[k]]) begin
        queue_load(a[k], 24'($urandom));
        n++;
      end
    end
    r = random_beat();
    r.req_type = REQ_COMPUTE;
    r.target_x = tx;
    r.target_y = ty;
    pending_beats.push_back(r);
  endtask

  // Random mix of compute beats and stray loads.
  task automatic queue_random(input int count);
    int made, n;
    req_t r;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 70) begin
        queue_compute(7'($urandom), 7'($urandom), n);
        made += n;
      end else begin
        r = random_beat();
        loaded_addr[r.pixel_address] = 1'b1;
        pending_beats.push_back(r);
        made++;
      end
    end
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    idle_cycles = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    shadow_cfg.frame_width = 9'd256;
    shadow_cfg.frame_height = 9'd256;
    shadow_cfg.crop_left = 8'd0;
    shadow_cfg.crop_top = 8'd0;
    shadow_cfg.crop_width = 9'd112;
    shadow_cfg.crop_height = 9'd112;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: saturating colors, grid corners, targets beyond the grid.
    set_geometry(256, 256, 0, 0, 112, 112);
    queue_load(0, 24'hffffff);
    queue_load(1, 24'hffffff);
    queue_load(256, 24'hffffff);
    queue_load(257, 24'hffffff);
    queue_compute(7'd0, 7'd0, n);
    queue_load(0, 24'h000000);
    queue_load(1, 24'h000000);
    queue_load(256, 24'h000000);
    queue_load(257, 24'h000000);
    queue_compute(7'd0, 7'd0, n);
    queue_load(65535, 24'hff00ff);
    queue_compute(7'd111, 7'd111, n);
    queue_compute(7'd127, 7'd127, n);
    queue_compute(7'd0, 7'd127, n);
    queue_compute(7'd127, 7'd0, n);
    drain();

    // Smallest frame, with a crop of a single pixel.
    set_geometry(2, 2, 0, 0, 1, 1);
    queue_random(90);
    drain();

    // Frame sizes below the minimum, crop origin at the far corner.
    set_geometry(0, 1, 255, 255, 256, 256);
    queue_random(90);
    drain();

    // All register bits set; frame sizes above the maximum.
    set_geometry(511, 511, 255, 255, 511, 511);
    queue_random(90);
    drain();

    // Zero crop size with no idling at all.
    calm = 1'b1;
    set_geometry(256, 256, 100, 50, 0, 0);
    queue_random(110);
    drain();
    calm = 1'b0;

    // Receiver holds off for a long stretch while the sender keeps offering.
    set_geometry(64, 48, 10, 5, 40, 30);
    hold_request = 1'b1;
    queue_random(110);
    drain();

    // Random settings for the rest of the run.
    for (int p = 0; p < 3; p++) begin
      set_geometry($urandom_range(511), $urandom_range(511), $urandom_range(255),
                   $urandom_range(255), $urandom_range(511), $urandom_range(511));
      queue_random(90);
      drain();
    end

    if (mismatches == 0) begin
      $display("[bilinear_crop_resize_quantize] OK");
    end else begin
      $display("[bilinear_crop_resize_quantize] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bcrq_pkg.sv
rtl/core/bcrq_ram.sv
rtl/core/bcrq_fifo.sv
rtl/core/bcrq_front.sv
rtl/core/bcrq_back.sv
rtl/core/bilinear_crop_resize_quantize.sv
rtl/core/bcrq_checker.sv
test/tb_bilinear_crop_resize_quantize.sv
